// ----- hw/rtl/newton_square_root_top_assert.svh -----
// Assertion macros for the Newton square root block.
`ifndef NEWTON_SQUARE_ROOT_TOP_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define NSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/nsr_pkg.sv -----
// Shared constants and types for the Newton square root block.
package nsr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned SqW      = DataW + FracBits;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned IterW    = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivCntW  = $clog2(SqW + 1);

  localparam logic [DataW-1:0]   TolReset  = DataW'(4295);
  localparam logic [IterW-1:0]   IterReset = IterW'(32);
  localparam logic [DataW-1:0]   GuessInit = DataW'(1) << FracBits;
  localparam logic [DataW-1:0]   DataMax   = '1;

  localparam logic [CfgIdxW-1:0] CfgTolerance = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxIter   = CfgIdxW'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- hw/rtl/nsr_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module nsr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nsr_pkg::SqW-1:0]   dividend_i,
  input  logic [nsr_pkg::DataW-1:0] divisor_i,
  output nsr_pkg::div_status_t      status_o,
  output logic [nsr_pkg::SqW-1:0]   quotient_o
);

  logic                          active_q, active_d;
  logic                          done_q, done_d;
  logic [nsr_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [nsr_pkg::SqW-1:0]       dvd_q, dvd_d;
  logic [nsr_pkg::DataW:0]       rem_q, rem_d;
  logic [nsr_pkg::DataW-1:0]     dsr_q, dsr_d;
  logic [nsr_pkg::DataW:0]       rem_sh;
  logic                          fits;

  assign rem_sh = {rem_q[nsr_pkg::DataW-1:0], dvd_q[nsr_pkg::SqW-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    if (start_i && !active_q) begin
      active_d = 1'b1;
      cnt_d    = nsr_pkg::DivCntW'(nsr_pkg::SqW);
      dvd_d    = dividend_i;
      rem_d    = '0;
      dsr_d    = divisor_i;
    end else if (active_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      dvd_d = {dvd_q[nsr_pkg::SqW-2:0], fits};
      cnt_d = cnt_q - nsr_pkg::DivCntW'(1);
      if (cnt_q == nsr_pkg::DivCntW'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign status_o.busy = active_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;

endmodule

// ----- hw/rtl/newton_square_root_top.sv -----
// Top level of the Newton square root block: sequencer, squarer, divider instance and config registers.
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------------------
//  input     start & !busy              x_value_i
//  result    done_o (one-cycle strobe)  root_o, converged_o, iterations_used_o
//  config    cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// A zero radicand goes straight to the done state; otherwise the block runs up to
// max_iterations Newton steps, each made of square, compare, divide in the radix-2 divider
// and update, and ends early when the guess is within tolerance or stops changing.
// busy stays high from acceptance through the done_o cycle; no new word is taken meanwhile.
// Reset clears the sequencer and loads tolerance 4295 and max_iterations 32.
// Results cannot be stalled: done_o marks a word that is taken in that same cycle.
module newton_square_root_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [nsr_pkg::DataW-1:0]   x_value_i,
  output logic                        done_o,
  output logic [nsr_pkg::DataW-1:0]   root_o,
  output logic                        converged_o,
  output logic [nsr_pkg::IterW-1:0]   iterations_used_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nsr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nsr_pkg::DataW-1:0]   cfg_data_i
);

  `include "newton_square_root_top_assert.svh"

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [nsr_pkg::DataW-1:0]       tol_q;
  logic [nsr_pkg::IterW-1:0]       max_iter_q;
  logic [nsr_pkg::SqW-1:0]         s_q, s_d;
  logic [nsr_pkg::DataW-1:0]       g_q, g_d;
  logic [nsr_pkg::ProdW-1:0]       sq_q, sq_d;
  logic [nsr_pkg::SqW-1:0]         q_q, q_d;
  logic [nsr_pkg::IterW-1:0]       iter_q, iter_d;
  logic                            conv_q, conv_d;

  logic                            div_start;
  nsr_pkg::div_status_t            div_st;
  logic [nsr_pkg::SqW-1:0]         div_quot;

  logic [nsr_pkg::ProdW-1:0]       s_ext;
  logic [nsr_pkg::ProdW-1:0]       diff;
  logic                            within_tol;
  logic [nsr_pkg::SqW:0]           sum;
  logic [nsr_pkg::SqW-1:0]         half;
  logic [nsr_pkg::DataW-1:0]       ng;

  nsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_q),
    .divisor_i  (g_q),
    .status_o   (div_st),
    .quotient_o (div_quot)
  );

  assign s_ext      = nsr_pkg::ProdW'(s_q);
  assign diff       = (s_ext >= sq_q) ? (s_ext - sq_q) : (sq_q - s_ext);
  assign within_tol = diff < nsr_pkg::ProdW'(tol_q);
  assign sum        = {1'b0, nsr_pkg::SqW'(g_q)} + {1'b0, q_q};
  assign half       = sum[nsr_pkg::SqW:1];
  assign ng         = (|half[nsr_pkg::SqW-1:nsr_pkg::DataW]) ? nsr_pkg::DataMax
                                                             : half[nsr_pkg::DataW-1:0];

  always_comb begin
    state_d   = state_q;
    s_d       = s_q;
    g_d       = g_q;
    sq_d      = sq_q;
    q_d       = q_q;
    iter_d    = iter_q;
    conv_d    = conv_q;
    div_start = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          iter_d = '0;
          if (x_value_i == '0) begin
            g_d     = '0;
            conv_d  = 1'b1;
            state_d = StDone;
          end else begin
            s_d     = {x_value_i, {nsr_pkg::FracBits{1'b0}}};
            g_d     = nsr_pkg::GuessInit;
            conv_d  = 1'b0;
            state_d = StMul;
          end
        end
      end
      StMul: begin
        sq_d    = nsr_pkg::ProdW'(g_q) * nsr_pkg::ProdW'(g_q);
        state_d = StChk;
      end
      StChk: begin
        if (within_tol) begin
          conv_d  = 1'b1;
          state_d = StDone;
        end else if (iter_q >= max_iter_q) begin
          state_d = StDone;
        end else if (g_q == '0) begin
          q_d     = nsr_pkg::SqW'(nsr_pkg::DataMax);
          state_d = StUpd;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_st.done) begin
          q_d     = div_quot;
          state_d = StUpd;
        end
      end
      StUpd: begin
        iter_d = iter_q + nsr_pkg::IterW'(1);
        if (ng == g_q) begin
          state_d = StDone;
        end else begin
          g_d     = ng;
          state_d = StMul;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      tol_q      <= nsr_pkg::TolReset;
      max_iter_q <= nsr_pkg::IterReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          nsr_pkg::CfgTolerance: tol_q      <= cfg_data_i;
          nsr_pkg::CfgMaxIter:   max_iter_q <= cfg_data_i[nsr_pkg::IterW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_d_hold: begin
      s_q    <= s_d;
      g_q    <= g_d;
      sq_q   <= sq_d;
      q_q    <= q_d;
      iter_q <= iter_d;
      conv_q <= conv_d;
    end
  end

  assign busy              = state_q != StIdle;
  assign cfg_ready_o       = 1'b1;
  assign done_o            = state_q == StDone;
  assign root_o            = g_q;
  assign converged_o       = conv_q;
  assign iterations_used_o = iter_q;

  `NSR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `NSR_ASSERT_NEXT(a_done_idle, done_o, !busy, "block not idle after result")
  `NSR_ASSERT_NOW(a_iter_cap, done_o, iterations_used_o <= max_iter_q, "step count above cap")
  `NSR_ASSERT_NOW(a_div_owner, div_st.busy, state_q == StDiv, "divider active outside wait")

endmodule

// ----- tb/sv/newton_square_root_top_tb.sv -----
// Self-checking testbench for the Newton square root block with a root predictor.
module newton_square_root_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsr_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int ResetCycles = 8;
  localparam int CycleLimit = 6_000_000;
  localparam int PhaseWords = 59;

  localparam logic [CfgIdxW-1:0] CfgSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpare3 = CfgIdxW'(3);

  typedef struct {
    logic [DataW-1:0] radicand;
    logic [DataW-1:0] root;
    logic             conv;
    logic [IterW-1:0] steps;
  } root_result_t;

  class root_checker;
    logic [DataW-1:0] tolerance_q;
    logic [IterW-1:0] iter_cap;
    root_result_t     pending[$];

    function new();
      tolerance_q = TolReset;
      iter_cap    = IterReset;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
      if (idx == CfgTolerance) begin
        tolerance_q = data;
      end else if (idx == CfgMaxIter) begin
        iter_cap = data[IterW-1:0];
      end
    endfunction

    function root_result_t newton_root(logic [DataW-1:0] x);
      logic [63:0]  scaled;
      logic [63:0]  guess;
      logic [63:0]  square;
      logic [63:0]  miss;
      logic [63:0]  quotient;
      logic [63:0]  next_guess;
      int           steps;
      bit           stop;
      root_result_t r;
      r.radicand = x;
      r.conv     = 1'b0;
      if (x == '0) begin
        r.root  = '0;
        r.conv  = 1'b1;
        r.steps = '0;
        return r;
      end
      scaled = 64'(x) << FracBits;
      guess  = 64'(GuessInit);
      steps  = 0;
      stop   = 1'b0;
      while (!stop) begin
        square = guess * guess;
        miss   = (scaled >= square) ? scaled - square : square - scaled;
        if (miss < 64'(tolerance_q)) begin
          r.conv = 1'b1;
          stop   = 1'b1;
        end else if (steps >= int'(iter_cap)) begin
          stop = 1'b1;
        end else begin
          quotient   = (guess != 0) ? scaled / guess : 64'(DataMax);
          next_guess = (guess + quotient) >> 1;
          if (next_guess > 64'(DataMax)) next_guess = 64'(DataMax);
          steps++;
          if (next_guess == guess) stop = 1'b1;
          else guess = next_guess;
        end
      end
      r.root  = guess[DataW-1:0];
      r.steps = IterW'(steps);
      return r;
    endfunction

    function void note_radicand(logic [DataW-1:0] x);
      pending.push_back(newton_root(x));
    endfunction

    function string check_root(logic [DataW-1:0] root, logic conv, logic [IterW-1:0] steps);
      root_result_t want;
      if (pending.size() == 0) begin
        return $sformatf("root %h converged %0d steps %0d with no word pending",
                         root, conv, steps);
      end
      want = pending.pop_front();
      if (root !== want.root || conv !== want.conv || steps !== want.steps) begin
        return $sformatf("x %h: root %h exp %h, converged %0d exp %0d, steps %0d exp %0d",
                         want.radicand, root, want.root, conv, want.conv, steps,
                         want.steps);
      end
      return "";
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [DataW-1:0]   x_value_i;
  logic               done_o;
  logic [DataW-1:0]   root_o;
  logic               converged_o;
  logic [IterW-1:0]   iterations_used_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0]   cfg_data_i;

  root_checker roots = new();
  int          mismatches = 0;
  int          cycles = 0;

  newton_square_root_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .x_value_i         (x_value_i),
    .done_o            (done_o),
    .root_o            (root_o),
    .converged_o       (converged_o),
    .iterations_used_o (iterations_used_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    string msg;
    cycles++;
    if (rst_ni && done_o) begin
      msg = roots.check_root(root_o, converged_o, iterations_used_o);
      if (msg != "") report_mismatch(msg);
    end
    if (cycles >= CycleLimit) begin
      $display("newton_square_root_top regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic [DataW-1:0] x, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    x_value_i <= x;
    do @(posedge clk_i); while (busy);
    roots.note_radicand(x);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (roots.pending_count() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    roots.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_radicand();
    int unsigned k;
    case ($urandom_range(0, 5))
      0: return $urandom >> $urandom_range(1, 31);
      1: begin
        k = $urandom_range(0, 255);
        return DataW'(k * k) << FracBits;
      end
      2: return DataW'($urandom_range(0, 3));
      3: return DataMax - DataW'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [DataW-1:0] pick_tolerance();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic run_phase(logic [DataW-1:0] tol, logic [IterW-1:0] cap, int idle_pct);
    wait_drained();
    write_reg(CfgTolerance, tol);
    write_reg(CfgMaxIter, cap);
    for (int i = 0; i < PhaseWords; i++) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_word(pick_radicand(), pick_gap(idle_pct));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    x_value_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgTolerance;
    cfg_data_i  = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero, smallest, largest, exact squares, powers of two
    send_word(32'h0000_0000, 0);
    send_word(32'h0000_0001, 0);
    send_word(32'hFFFF_FFFF, 0);
    send_word(32'h0001_0000, 0);
    send_word(32'h0004_0000, 0);
    send_word(32'h8000_0000, 0);
    send_word(32'h0000_0002, 0);

    // strict test never passes for nonzero words: end on no change or on the cap
    wait_drained();
    write_reg(CfgTolerance, '0);
    write_reg(CfgMaxIter, IterW'(63));
    send_word(32'h0001_0000, 0);
    send_word(32'h0002_0000, 0);
    send_word(32'hFFFF_FFFF, 0);
    send_word(32'h0000_0001, 0);
    send_word(32'h0000_0000, 0);

    wait_drained();
    write_reg(CfgTolerance, DataMax);
    write_reg(CfgMaxIter, IterW'(1));
    send_word(32'h0001_8000, 0);
    send_word(32'h0003_0000, 0);
    send_word(32'hFFFF_FFFF, 0);

    // no steps allowed: only the initial guess is tested
    wait_drained();
    write_reg(CfgTolerance, TolReset);
    write_reg(CfgMaxIter, '0);
    send_word(32'h0001_0000, 0);
    send_word(32'h0009_0000, 0);
    send_word(32'h0000_0000, 0);

    // unused indexes leave both registers alone
    wait_drained();
    write_reg(CfgSpare2, $urandom);
    write_reg(CfgSpare3, $urandom);
    send_word(32'h0009_0000, 0);

    run_phase(TolReset, IterReset, 0);
    run_phase(pick_tolerance(), IterW'($urandom_range(1, 63)), 51);
    run_phase('0, IterW'($urandom_range(8, 63)), 0);
    run_phase(pick_tolerance(), IterW'(63), 10);
    run_phase(pick_tolerance(), IterW'($urandom_range(1, 6)), 51);
    run_phase(pick_tolerance(), IterW'($urandom_range(1, 63)), 0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && roots.pending_count() == 0) begin
      $display("newton_square_root_top regression: pass");
    end else begin
      $display("newton_square_root_top regression: fail");
    end
    $finish;
  end

endmodule
